[rtl/core/pcu3_pkg.sv]
// Shared widths, constants and register indexes for the palette unmix block.
`default_nettype none
package pcu3_pkg;
    localparam int CH_W          = 16;
    localparam int CFG_W         = 48;
    localparam int W_W           = 24;
    localparam int DEF_FRAC_BITS = 12;
    localparam int IDX_W         = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COLOR_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLOR_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_COLOR_C = 2'd2;

    // saturation limits as magnitudes
    localparam logic [W_W-1:0] WMAX_MAG = 24'h7F_FFFF;
    localparam logic [W_W-1:0] WMIN_MAG = 24'h80_0000;
endpackage
`default_nettype wire

[rtl/core/pcu3_pix_if.sv]
// Pixel input channel: valid/ready with three signed channels.
`default_nettype none
interface pcu3_pix_if;
    logic                               valid;
    logic                               ready;
    logic signed [pcu3_pkg::CH_W-1:0]   chan_zero;
    logic signed [pcu3_pkg::CH_W-1:0]   chan_one;
    logic signed [pcu3_pkg::CH_W-1:0]   chan_two;

    modport source (output valid, chan_zero, chan_one, chan_two, input ready);
    modport sink   (input valid, chan_zero, chan_one, chan_two, output ready);
endinterface
`default_nettype wire

[rtl/core/pcu3_wgt_if.sv]
// Weight output channel: valid/ready with three weights and two flags.
`default_nettype none
interface pcu3_wgt_if;
    logic                               valid;
    logic                               ready;
    logic signed [pcu3_pkg::W_W-1:0]    weight_a;
    logic signed [pcu3_pkg::W_W-1:0]    weight_b;
    logic signed [pcu3_pkg::W_W-1:0]    weight_c;
    logic                               singular;
    logic                               saturated;

    modport source (output valid, weight_a, weight_b, weight_c, singular, saturated,
                    input ready);
    modport sink   (input valid, weight_a, weight_b, weight_c, singular, saturated,
                     output ready);
endinterface
`default_nettype wire

[rtl/core/palette_color_unmix_3x3_top.sv]
// Top level: pipelined 3x3 Cramer solve of a pixel against a three-color palette.
//
//  channel | dir | handshake        | beat contents
//  pix     | in  | valid/ready      | chan_zero, chan_one, chan_two
//  wgt     | out | valid/ready      | weight_a/b/c, singular, saturated
//  cfg     | in  | cfg_we, no ready | cfg_idx, cfg_data
//
// One beat per cycle sustained while the output does not stall; 5 stages of products,
// minors and sums, one overflow check, 24 one-bit restoring divide stages
// shared by the three weights, one saturation/output stage.
// Reset clears the palette and all stage valid bits.
// A stalled output holds the whole pipeline; pix.ready is low while it stalls.
`default_nettype none
module palette_color_unmix_3x3_top #(
    parameter int FRAC_BITS = pcu3_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    pcu3_pix_if.sink                            pix,
    pcu3_wgt_if.source                          wgt,
    input  wire logic                           cfg_we,
    input  wire logic [pcu3_pkg::IDX_W-1:0]     cfg_idx,
    input  wire logic [pcu3_pkg::CFG_W-1:0]     cfg_data
);
    localparam int CW  = pcu3_pkg::CH_W;
    localparam int WW  = pcu3_pkg::W_W;
    localparam int PW  = 2 * CW;          // 2x2 product
    localparam int MNW = PW + 1;          // minor
    localparam int TW  = CW + MNW;        // channel times minor
    localparam int MW  = TW + 3;          // sum of three terms
    localparam int QB  = WW;              // quotient bits
    localparam int RW  = MW + QB;         // remainder width
    localparam int NST = QB + 7;          // total stages

    // palette registers
    logic [pcu3_pkg::CFG_W-1:0] cfg_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= '0;
            cfg_reg[1] <= '0;
            cfg_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                pcu3_pkg::REG_COLOR_A: cfg_reg[0] <= cfg_data;
                pcu3_pkg::REG_COLOR_B: cfg_reg[1] <= cfg_data;
                pcu3_pkg::REG_COLOR_C: cfg_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: everything moves together unless the output stalls
    logic           vld_reg [NST];
    logic           adv;

    assign adv       = !vld_reg[NST-1] || wgt.ready;
    assign pix.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= pix.valid;
            for (int s = 1; s < NST; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // matrix columns and pixel
    logic signed [CW-1:0] col_w [3][3];
    logic signed [CW-1:0] pin_w [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++)
                col_w[k][r] = signed'(cfg_reg[k][CW*r +: CW]);
        pin_w[0] = pix.chan_zero;
        pin_w[1] = pix.chan_one;
        pin_w[2] = pix.chan_two;
    end

    // stage 1: cross products of the 2x2 minors (minor k leaves out column k)
    logic signed [PW-1:0] hi_next [3][3];
    logic signed [PW-1:0] lo_next [3][3];
    logic signed [PW-1:0] hi_reg  [3][3];
    logic signed [PW-1:0] lo_reg  [3][3];
    logic signed [CW-1:0] p1_reg  [3];
    logic signed [CW-1:0] a1_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++)
            begin
                hi_next[k][r] = col_w[(k == 0) ? 1 : 0][(r == 0) ? 1 : 0]
                              * col_w[(k == 2) ? 1 : 2][(r == 2) ? 1 : 2];
                lo_next[k][r] = col_w[(k == 0) ? 1 : 0][(r == 2) ? 1 : 2]
                              * col_w[(k == 2) ? 1 : 2][(r == 0) ? 1 : 0];
            end
    end

    // stage 2: minors
    logic signed [MNW-1:0] min_next [3][3];
    logic signed [MNW-1:0] min_reg  [3][3];
    logic signed [CW-1:0]  p2_reg   [3];
    logic signed [CW-1:0]  a2_reg   [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++)
                min_next[k][r] = MNW'(hi_reg[k][r]) - MNW'(lo_reg[k][r]);
    end

    // stage 3: channel times minor, and palette column a for the determinant
    logic signed [TW-1:0] trm_next  [3][3];
    logic signed [TW-1:0] trm_reg   [3][3];
    logic signed [TW-1:0] dtrm_next [3];
    logic signed [TW-1:0] dtrm_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++)
                trm_next[k][r] = p2_reg[r] * min_reg[k][r];
        for (int r = 0; r < 3; r++)
            dtrm_next[r] = a2_reg[r] * min_reg[0][r];
    end

    // stage 4: alternating sums give numerators and determinant
    logic signed [MW-1:0] num_next [3];
    logic signed [MW-1:0] num_reg  [3];
    logic signed [MW-1:0] det_next;
    logic signed [MW-1:0] det_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            num_next[k] = MW'(trm_reg[k][0]) - MW'(trm_reg[k][1]) + MW'(trm_reg[k][2]);
        det_next = MW'(dtrm_reg[0]) - MW'(dtrm_reg[1]) + MW'(dtrm_reg[2]);
    end

    // stage 5: magnitudes and result signs; weight b's numerator is negated
    logic [MW-1:0] nmag_next [3];
    logic [MW-1:0] nmag_reg  [3];
    logic          neg_next  [3];
    logic          neg_reg   [3];
    logic [MW-1:0] dmag_next;
    logic [MW-1:0] dmag_reg;
    logic          sng_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nmag_next[k] = num_reg[k][MW-1] ? MW'(-num_reg[k]) : MW'(num_reg[k]);
            neg_next[k]  = num_reg[k][MW-1] ^ det_reg[MW-1] ^ (k == 1);
        end
        dmag_next = det_reg[MW-1] ? MW'(-det_reg) : MW'(det_reg);
    end

    // divide stages: index 0 holds the overflow check, index j has j bits done
    logic [RW-1:0] rem_reg [QB+1][3];
    logic [QB-1:0] q_reg   [QB+1][3];
    logic          ovf_reg [QB+1][3];
    logic          ng_reg  [QB+1][3];
    logic [MW-1:0] dv_reg  [QB+1];
    logic          sg_reg  [QB+1];
    logic [RW-1:0] rem0_next [3];
    logic          ovf0_next [3];
    logic [RW-1:0] rem_next  [QB][3];
    logic [QB-1:0] q_next    [QB][3];

    always_comb
    begin
        logic [RW-1:0] t;
        for (int k = 0; k < 3; k++)
        begin
            rem0_next[k] = RW'(nmag_reg[k]) << FRAC_BITS;
            ovf0_next[k] = rem0_next[k] >= (RW'(dmag_reg) << QB);
        end
        for (int j = 0; j < QB; j++)
        begin
            t = RW'(dv_reg[j]) << (QB - 1 - j);
            for (int k = 0; k < 3; k++)
            begin
                if (rem_reg[j][k] >= t)
                begin
                    rem_next[j][k] = rem_reg[j][k] - t;
                    q_next[j][k]   = {q_reg[j][k][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][k] = rem_reg[j][k];
                    q_next[j][k]   = {q_reg[j][k][QB-2:0], 1'b0};
                end
            end
        end
    end

    // output stage: clip, apply sign, force zero on a singular palette
    logic [WW-1:0]        lim_w [3];
    logic                 sat_w [3];
    logic [WW-1:0]        mag_w [3];
    logic signed [WW-1:0] w_next [3];
    logic                 sat_next;
    logic signed [WW-1:0] w_reg  [3];
    logic                 sat_reg;
    logic                 osng_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lim_w[k]  = ng_reg[QB][k] ? pcu3_pkg::WMIN_MAG : pcu3_pkg::WMAX_MAG;
            sat_w[k]  = ovf_reg[QB][k] || (q_reg[QB][k] > lim_w[k]);
            mag_w[k]  = sat_w[k] ? lim_w[k] : q_reg[QB][k];
            w_next[k] = sg_reg[QB] ? '0 : (ng_reg[QB][k] ? -mag_w[k] : mag_w[k]);
        end
        sat_next = !sg_reg[QB] && (sat_w[0] || sat_w[1] || sat_w[2]);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            p1_reg   <= pin_w;
            a1_reg   <= col_w[0];
            min_reg  <= min_next;
            p2_reg   <= p1_reg;
            a2_reg   <= a1_reg;
            trm_reg  <= trm_next;
            dtrm_reg <= dtrm_next;
            num_reg  <= num_next;
            det_reg  <= det_next;
            nmag_reg <= nmag_next;
            neg_reg  <= neg_next;
            dmag_reg <= dmag_next;
            sng_reg  <= (det_reg == '0);
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= rem0_next[k];
                q_reg[0][k]   <= '0;
                ovf_reg[0][k] <= ovf0_next[k];
                ng_reg[0][k]  <= neg_reg[k];
            end
            dv_reg[0] <= dmag_reg;
            sg_reg[0] <= sng_reg;
            for (int j = 0; j < QB; j++)
            begin
                rem_reg[j+1] <= rem_next[j];
                q_reg[j+1]   <= q_next[j];
                ovf_reg[j+1] <= ovf_reg[j];
                ng_reg[j+1]  <= ng_reg[j];
                dv_reg[j+1]  <= dv_reg[j];
                sg_reg[j+1]  <= sg_reg[j];
            end
            w_reg    <= w_next;
            sat_reg  <= sat_next;
            osng_reg <= sg_reg[QB];
        end
    end

    assign wgt.valid     = vld_reg[NST-1];
    assign wgt.weight_a  = w_reg[0];
    assign wgt.weight_b  = w_reg[1];
    assign wgt.weight_c  = w_reg[2];
    assign wgt.singular  = osng_reg;
    assign wgt.saturated = sat_reg;

    // checks
    a_sng_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wgt.valid && wgt.singular |-> wgt.weight_a == '0 && wgt.weight_b == '0 &&
                                      wgt.weight_c == '0 && !wgt.saturated)
        else $error("singular beat with nonzero weights or saturation");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wgt.valid && !wgt.ready |-> !pix.ready)
        else $error("input taken while output stalled");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        wgt.valid && !wgt.ready |=> wgt.valid && $stable(w_reg[0]) && $stable(sat_reg))
        else $error("stalled result changed");
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for the palette unmix block: streamed pixels against a predicted solve.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pcu3_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] c2;
    } pixel_t;

    typedef struct packed {
        logic [W_W-1:0] wa;
        logic [W_W-1:0] wb;
        logic [W_W-1:0] wc;
        logic           sing;
        logic           sat;
    } weights_t;

    typedef longint vec3_t [3];

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    pcu3_pix_if pix ();
    pcu3_wgt_if wgt ();

    palette_color_unmix_3x3_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix),
        .wgt      (wgt),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // palette copy, pending pixels, expected weights
    logic [CFG_W-1:0] palette [3];
    pixel_t   pix_pending [$];
    weights_t weights_expected [$];
    pixel_t   px;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    bit failed;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic vec3_t unpack_color(logic [CFG_W-1:0] v);
        vec3_t col;
        col[0] = longint'($signed(v[15:0]));
        col[1] = longint'($signed(v[31:16]));
        col[2] = longint'($signed(v[47:32]));
        return col;
    endfunction

    // determinant with columns x, y, z
    function automatic longint det_cols(vec3_t x, vec3_t y, vec3_t z);
        return x[0] * (y[1] * z[2] - y[2] * z[1])
             - y[0] * (x[1] * z[2] - x[2] * z[1])
             + z[0] * (x[1] * y[2] - x[2] * y[1]);
    endfunction

    // num * 2^FRAC / den, truncated toward zero, clipped to 24 bits
    function automatic logic [W_W-1:0] scaled_quotient(longint num, longint den, inout bit sat);
        logic [63:0] n, d, ip, r, frac, mag, lim;
        bit neg;
        n = num < 0 ? 64'(-num) : 64'(num);
        d = den < 0 ? 64'(-den) : 64'(den);
        neg = (num < 0) != (den < 0);
        ip = n / d;
        r = n % d;
        frac = 0;
        lim = neg ? 64'(WMIN_MAG) : 64'(WMAX_MAG);
        if (ip >= (64'd1 << 24))
            mag = lim + 1;
        else
        begin
            for (int i = 0; i < FRAC; i++)
            begin
                r = r << 1;
                frac = frac << 1;
                if (r >= d)
                begin
                    r = r - d;
                    frac = frac | 64'd1;
                end
            end
            mag = (ip << FRAC) | frac;
        end
        if (mag > lim)
        begin
            mag = lim;
            sat = 1'b1;
        end
        if (neg)
            mag = 64'd0 - mag;
        return mag[W_W-1:0];
    endfunction

    function automatic weights_t predict_weights(pixel_t p);
        vec3_t a, b, c, v;
        longint d;
        bit sat;
        weights_t w;
        a = unpack_color(palette[0]);
        b = unpack_color(palette[1]);
        c = unpack_color(palette[2]);
        v[0] = longint'($signed(p.c0));
        v[1] = longint'($signed(p.c1));
        v[2] = longint'($signed(p.c2));
        d = det_cols(a, b, c);
        w = '0;
        sat = 1'b0;
        if (d == 0)
        begin
            w.sing = 1'b1;
            return w;
        end
        w.wa = scaled_quotient(det_cols(v, b, c), d, sat);
        w.wb = scaled_quotient(det_cols(a, v, c), d, sat);
        w.wc = scaled_quotient(det_cols(a, b, v), d, sat);
        w.sat = sat;
        return w;
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid     <= 1'b0;
            pix.chan_zero <= '0;
            pix.chan_one  <= '0;
            pix.chan_two  <= '0;
        end
        else
        begin
            if (pix.valid && pix.ready)
                weights_expected.push_back(predict_weights({pix.chan_zero, pix.chan_one,
                                                            pix.chan_two}));
            if (!pix.valid || pix.ready)
            begin
                if (pix_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    px = pix_pending.pop_front();
                    pix.valid     <= 1'b1;
                    pix.chan_zero <= px.c0;
                    pix.chan_one  <= px.c1;
                    pix.chan_two  <= px.c2;
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= 300;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(string name, logic [W_W-1:0] exp_v, logic [W_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // weight monitor
    always @(posedge clk or negedge rst_n)
    begin
        weights_t w;
        if (!rst_n)
            wgt.ready <= 1'b0;
        else
        begin
            if (wgt.valid && wgt.ready)
            begin
                if (weights_expected.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h %h %h", $time,
                             wgt.weight_a, wgt.weight_b, wgt.weight_c);
                    failed = 1'b1;
                end
                else
                begin
                    w = weights_expected.pop_front();
                    check_field("weight_a", w.wa, wgt.weight_a);
                    check_field("weight_b", w.wb, wgt.weight_b);
                    check_field("weight_c", w.wc, wgt.weight_c);
                    check_field("singular", W_W'(w.sing), W_W'(wgt.singular));
                    check_field("saturated", W_W'(w.sat), W_W'(wgt.saturated));
                end
            end
            wgt.ready <= (hold_seen == hold_req) && (hold_left == 0)
                         && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx <= REG_COLOR_C)
            palette[idx] = data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_palette(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b, logic [CFG_W-1:0] c);
        write_reg(REG_COLOR_A, a);
        write_reg(REG_COLOR_B, b);
        write_reg(REG_COLOR_C, c);
    endtask

    // wait until all beats are back, then let the pipeline settle
    task automatic drain();
        while (pix_pending.size() > 0 || pix.valid || weights_expected.size() > 0
               || hold_left > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_pixel(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1, logic [CH_W-1:0] c2);
        pixel_t p;
        p.c0 = c0;
        p.c1 = c1;
        p.c2 = c2;
        pix_pending.push_back(p);
    endtask

    function automatic logic [CFG_W-1:0] rand_color(int kind);
        logic [CFG_W-1:0] v;
        if (kind == 0)
            v = {16'($urandom), 16'($urandom), 16'($urandom)};
        else
            v = {16'($urandom_range(128) - 64), 16'($urandom_range(128) - 64),
                 16'($urandom_range(128) - 64)};
        return v;
    endfunction

    function automatic logic [CH_W-1:0] rand_chan(int kind);
        return kind == 0 ? CH_W'($urandom) : CH_W'($urandom_range(512) - 256);
    endfunction

    task automatic queue_edges();
        queue_pixel(16'h0000, 16'h0000, 16'h0000);
        queue_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_pixel(16'h8000, 16'h8000, 16'h8000);
        queue_pixel(16'h7FFF, 16'h8000, 16'h0001);
        queue_pixel(16'hFFFF, 16'h0001, 16'h8000);
        queue_pixel(16'h0003, 16'hFFFD, 16'h0002);
    endtask

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] a, b;
        int kind;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        palette[0] = '0;
        palette[1] = '0;
        palette[2] = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        failed = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset palette is singular
        queue_edges();
        drain();

        // unit palette: large pixels saturate
        set_palette(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000);
        queue_edges();
        queue_pixel(16'h07FF, 16'hF800, 16'h0001);
        drain();

        // extreme diagonal palette
        set_palette(48'h0000_0000_8000, 48'h0000_7FFF_0000, 48'h8000_0000_0000);
        queue_edges();
        drain();

        // all-max and all-min palette is rank one; unknown index is ignored
        set_palette(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000);
        write_reg(2'd3, 48'hFFFF_FFFF_FFFF);
        queue_edges();
        drain();

        // random phases with rotating idle patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            kind = ph % 3;
            a = rand_color(kind == 2 ? 1 : 0);
            b = rand_color(kind == 2 ? 1 : 0);
            if (ph == 6)
                set_palette(a, b, a);
            else
                set_palette(a, b, rand_color(kind == 2 ? 1 : 0));
            write_reg(2'd3, CFG_W'({$urandom, $urandom}));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (ph == 4)
                hold_req = hold_req + 1;
            for (int i = 0; i < 90; i++)
                queue_pixel(rand_chan(i % 2), rand_chan(i % 3 == 0 ? 1 : 0),
                            rand_chan(($urandom_range(1))));
            drain();
        end

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
